[rtl/sgcp_pkg.sv]
// Shared constants and types for the serial gain command parser.
`timescale 1ns / 1ps

package sgcp_pkg;

   localparam int STATE_W = 7;
   localparam int BYTE_W  = 8;

   // Parser state encoding
   localparam logic [STATE_W-1:0] ST_IDLE    = 7'd0;
   localparam logic [STATE_W-1:0] ST_FIRST_S = 7'd1;
   localparam logic [STATE_W-1:0] ST_FIRST_K = 7'd5;
   localparam logic [STATE_W-1:0] ST_KEY_MIN = 7'd10;   // key states lie above this
   localparam logic [STATE_W-1:0] ST_KEY_SS  = 7'd11;
   localparam logic [STATE_W-1:0] ST_KEY_SA  = 7'd12;
   localparam logic [STATE_W-1:0] ST_KEY_KP  = 7'd15;
   localparam logic [STATE_W-1:0] ST_KEY_KI  = 7'd16;
   localparam logic [STATE_W-1:0] ST_KEY_KD  = 7'd17;
   localparam logic [STATE_W-1:0] ST_DATA_S  = 7'd19;
   localparam logic [STATE_W-1:0] ST_DATA_P  = 7'd20;
   localparam logic [STATE_W-1:0] ST_DATA_I  = 7'd21;
   localparam logic [STATE_W-1:0] ST_DATA_D  = 7'd22;
   localparam logic [STATE_W-1:0] ST_DATA_A  = 7'd45;
   localparam logic [STATE_W-1:0] ST_DATA_LO = 7'd19;
   localparam logic [STATE_W-1:0] ST_DATA_HI = 7'd66;
   localparam logic [STATE_W-1:0] ST_DONE_HI = 7'd76;
   localparam logic [STATE_W-1:0] DATA_STEP  = 7'd10;

   // Second-letter offsets from the first-letter state
   localparam logic [STATE_W-1:0] OFS_SP = 7'd10;
   localparam logic [STATE_W-1:0] OFS_AI = 7'd11;
   localparam logic [STATE_W-1:0] OFS_D  = 7'd12;

   // ASCII codes
   localparam logic [BYTE_W-1:0] CH_EQ = 8'h3D;  // '='
   localparam logic [BYTE_W-1:0] CH_O  = 8'h6F;  // 'o'
   localparam logic [BYTE_W-1:0] CH_S  = 8'h73;  // 's'
   localparam logic [BYTE_W-1:0] CH_K  = 8'h6B;  // 'k'
   localparam logic [BYTE_W-1:0] CH_A  = 8'h61;  // 'a'
   localparam logic [BYTE_W-1:0] CH_P  = 8'h70;  // 'p'
   localparam logic [BYTE_W-1:0] CH_I  = 8'h69;  // 'i'
   localparam logic [BYTE_W-1:0] CH_D  = 8'h64;  // 'd'

   typedef struct packed {
      logic                emit;
      logic [BYTE_W-1:0]   out_byte;
      logic [STATE_W-1:0]  next_state;
   } sgcp_step_type;

endpackage

[rtl/sgcp_decode.sv]
// Next-state and result decode for one received byte.
`timescale 1ns / 1ps

module sgcp_decode
   import sgcp_pkg::*;
(
   input  logic               enable,
   input  logic [STATE_W-1:0] state,
   input  logic [BYTE_W-1:0]  rx_byte,
   output sgcp_step_type      step
);

   logic [STATE_W-1:0] q;
   logic               emit;
   logic [BYTE_W-1:0]  ob;

   always_comb begin
      q    = state;
      emit = 1'b0;
      ob   = rx_byte;

      // Data phase, end marker, or key completion on '='
      if (q > ST_DATA_HI && q <= ST_DONE_HI) begin
         emit = 1'b1;
         ob   = CH_O;
         q    = ST_IDLE;
      end else if (q >= ST_DATA_LO && q <= ST_DATA_HI) begin
         emit = 1'b1;
         q    = (rx_byte == CH_EQ) ? ST_IDLE : q + DATA_STEP;
      end else if (rx_byte == CH_EQ && q > ST_KEY_MIN) begin
         unique case (q)
            ST_KEY_SS: begin q = ST_DATA_S; emit = 1'b1; ob = CH_S; end
            ST_KEY_SA: begin q = ST_DATA_A; emit = 1'b1; ob = CH_A; end
            ST_KEY_KP: begin q = ST_DATA_P; emit = 1'b1; ob = CH_P; end
            ST_KEY_KI: begin q = ST_DATA_I; emit = 1'b1; ob = CH_I; end
            ST_KEY_KD: begin q = ST_DATA_D; emit = 1'b1; ob = CH_D; end
            default:   q = ST_IDLE;
         endcase
      end

      // Second letter of a key; a bad letter falls back to idle
      if (q == ST_FIRST_S || q == ST_FIRST_K) begin
         case (rx_byte) inside
            CH_A, CH_I: q = q + OFS_AI;
            CH_S, CH_P: q = q + OFS_SP;
            CH_D:       q = q + OFS_D;
            default:    q = ST_IDLE;
         endcase
      end

      // First letter, also re-examining the byte after an abort
      if (q == ST_IDLE) begin
         if (rx_byte == CH_S) begin
            q = ST_FIRST_S;
         end else if (rx_byte == CH_K) begin
            q = ST_FIRST_K;
         end
      end

      if (!enable) begin
         step.emit       = 1'b0;
         step.out_byte   = rx_byte;
         step.next_state = state;
      end else begin
         step.emit       = emit;
         step.out_byte   = ob;
         step.next_state = q;
      end
   end

endmodule

[rtl/serial_gain_command_parser.sv]
// Top level of the serial gain command parser: channels, state and result register.
`timescale 1ns / 1ps

// Usage:
//  - req channel: one received byte per transfer (req_rx_byte). A byte is
//    taken at a rising edge with req_valid high and req_stall low.
//  - rsp channel: zero or one result byte per input byte (rsp_out_byte):
//    a key tag letter, a passed data byte, or the 'o' end marker.
//  - csr port: csr_we writes csr_wdata into parse_enable. With parsing
//    disabled every byte is taken and dropped and the parser state holds.
//  - Result: registered; it appears on rsp in the cycle after its byte is taken.
//  - Throughput: one byte per cycle while req_stall is low; the parser
//    state advances through a combinational decode, and the result register
//    refills in the cycle it drains, so back-to-back transfers flow with no bubbles.
//  - Stall: when the result register holds a byte and rsp_stall is high,
//    req_stall rises and the pending result holds until it is taken.
//  - Reset (synchronous, active high): parser goes idle, parsing is
//    disabled and the result register is emptied.
module serial_gain_command_parser
   import sgcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // input byte channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   // configuration
   input  logic              csr_we,
   input  logic              csr_wdata
);

   logic [STATE_W-1:0] state_ff, state_in;
   logic               enable_ff, enable_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               accept;
   sgcp_step_type      step;

   // Block input only while a result is waiting and the receiver stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   sgcp_decode u_decode (
      .enable  (enable_ff),
      .state   (state_ff),
      .rx_byte (req_rx_byte),
      .step    (step)
   );

   always_comb begin
      enable_in = csr_we ? csr_wdata : enable_ff;
      // Advance the parser only on an accepted transfer
      state_in  = accept ? step.next_state : state_ff;
      // Load a new result, else hold a stalled one, else drain
      rsp_valid_in = (accept && step.emit) || (rsp_valid_ff && rsp_stall);
      rsp_byte_in  = (accept && step.emit) ? step.out_byte : rsp_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register: no reset needed
   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

`ifndef ASSERT_OFF
   // Parser state never leaves the encoded range
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff <= ST_DONE_HI)
      else $error("parser state out of range");

   // A transfer taken while parsing is disabled leaves the state untouched
   a_disabled_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !enable_ff |=> $stable(state_ff))
      else $error("state moved while parsing disabled");

   // A byte taken in the end-marker window always yields a result
   a_end_marker: assert property (@(posedge clock) disable iff (reset)
      accept && enable_ff && state_ff > ST_DATA_HI |=> rsp_valid_ff && rsp_byte_ff == CH_O)
      else $error("end marker missing");

   // Data bytes are passed on unchanged
   a_data_pass: assert property (@(posedge clock) disable iff (reset)
      accept && enable_ff && state_ff >= ST_DATA_LO && state_ff <= ST_DATA_HI
      |=> rsp_valid_ff && rsp_byte_ff == $past(req_rx_byte))
      else $error("data byte not passed");
`endif

endmodule

[verif/serial_gain_command_parser_test.sv]
// Self-checking testbench for the serial gain command parser.
`timescale 1ns / 1ps

module serial_gain_command_parser_test;
   import sgcp_pkg::*;

   // Length of the one long hold on the result register, in the no-idle phase,
   // so the parser fills up and pushes back on its input.
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 3;    // result appears in the cycle after its byte
   localparam int DIR_ROWS = 26;

   // One row of the directed table. Where "typed" is set the expected result is
   // written in the row; otherwise the parser model supplies it.
   typedef struct {
      logic              parse_en;
      logic [BYTE_W-1:0] rx;
      bit                typed;
      bit                emit;
      logic [BYTE_W-1:0] out;
   } dir_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_rx_byte = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              csr_we = 1'b0;
   logic              csr_wdata = 1'b0;

   // Model copy of the parser: state and the enable register.
   logic [STATE_W-1:0] parse_state_mirror = ST_IDLE;
   logic               parse_en_mirror = 1'b0;

   logic [BYTE_W-1:0] pending_out_bytes [$];
   int                fail_count = 0;
   int                sent_bytes = 0;     // every input transfer
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   bit                hold_arm = 1'b0;
   bit                hold_done = 1'b0;
   int                hold_left = 0;

   logic [BYTE_W-1:0] key_seconds [5] = '{CH_S, CH_P, CH_A, CH_I, CH_D};

   dir_row_type directed_rows [DIR_ROWS] = '{
      // parsing off: a full key prefix is dropped
      '{1'b0, CH_S,  1'b1, 1'b0, 8'h00},
      '{1'b0, CH_EQ, 1'b1, 1'b0, 8'h00},
      // bad second letter that is no first letter either: back to idle
      '{1'b1, CH_S,  1'b1, 1'b0, 8'h00},
      '{1'b1, 8'h78, 1'b1, 1'b0, 8'h00},
      // key ks; a stray byte while waiting for '=' is ignored
      '{1'b1, CH_K,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_S,  1'b1, 1'b0, 8'h00},
      '{1'b1, 8'h3F, 1'b1, 1'b0, 8'h00},
      '{1'b1, CH_EQ, 1'b1, 1'b1, CH_P},
      // data extremes, then '=' inside the data aborts to idle
      '{1'b1, 8'h00, 1'b1, 1'b1, 8'h00},
      '{1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF},
      '{1'b1, CH_EQ, 1'b1, 1'b1, CH_EQ},
      // key sd: '=' returns to idle silently
      '{1'b1, CH_S,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_D,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_EQ, 1'b1, 1'b0, 8'h00},
      // bad second letter 'k' restarts a key: ki
      '{1'b1, CH_S,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_K,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_I,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_EQ, 1'b1, 1'b1, CH_I},
      '{1'b1, 8'h80, 1'b0, 1'b0, 8'h00},
      '{1'b1, 8'h7F, 1'b0, 1'b0, 8'h00},
      '{1'b1, 8'h31, 1'b0, 1'b0, 8'h00},
      '{1'b1, 8'h32, 1'b0, 1'b0, 8'h00},
      '{1'b1, 8'h55, 1'b0, 1'b0, 8'h00},
      // end marker, and the same byte opens key sa
      '{1'b1, CH_S,  1'b1, 1'b1, CH_O},
      '{1'b1, CH_A,  1'b1, 1'b0, 8'h00},
      '{1'b1, CH_EQ, 1'b1, 1'b1, CH_A}
   };

   serial_gain_command_parser dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Parser model: next state and the result, if any, caused by one byte.
   function automatic sgcp_step_type parse_step(input logic [STATE_W-1:0] st,
                                                input logic               en,
                                                input logic [BYTE_W-1:0]  c);
      sgcp_step_type      r;
      logic [STATE_W-1:0] q;
      r.emit = 1'b0;
      r.out_byte = '0;
      q = st;
      if (!en) begin
         r.next_state = st;
         return r;
      end
      if (q > ST_DATA_HI && q <= ST_DONE_HI) begin
         // data complete: this byte closes the command
         r.emit = 1'b1;
         r.out_byte = CH_O;
         q = ST_IDLE;
      end else if (q >= ST_DATA_LO && q <= ST_DATA_HI) begin
         r.emit = 1'b1;
         r.out_byte = c;
         q = (c == CH_EQ) ? ST_IDLE : q + DATA_STEP;
      end else if (c == CH_EQ && q > ST_KEY_MIN) begin
         case (q)
            ST_KEY_SS: begin q = ST_DATA_S; r.emit = 1'b1; r.out_byte = CH_S; end
            ST_KEY_SA: begin q = ST_DATA_A; r.emit = 1'b1; r.out_byte = CH_A; end
            ST_KEY_KP: begin q = ST_DATA_P; r.emit = 1'b1; r.out_byte = CH_P; end
            ST_KEY_KI: begin q = ST_DATA_I; r.emit = 1'b1; r.out_byte = CH_I; end
            ST_KEY_KD: begin q = ST_DATA_D; r.emit = 1'b1; r.out_byte = CH_D; end
            default:   q = ST_IDLE;
         endcase
      end
      if (q == ST_FIRST_S || q == ST_FIRST_K) begin
         case (c) inside
            CH_A, CH_I: q = q + OFS_AI;
            CH_S, CH_P: q = q + OFS_SP;
            CH_D:       q = q + OFS_D;
            default:    q = ST_IDLE;
         endcase
      end
      // idle (or just dropped back to idle): look for a first letter
      if (q == ST_IDLE) begin
         if (c == CH_S)
            q = ST_FIRST_S;
         else if (c == CH_K)
            q = ST_FIRST_K;
      end
      r.next_state = q;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                  input logic [BYTE_W-1:0] want);
      fail_count++;
      $display("%0t: %s: out_byte got 8'h%02h, expected 8'h%02h", $time, what, got, want);
   endtask

   // Offer one byte, with random idle cycles in front, and hold it until taken.
   // On the transfer, advance the model and queue any expected result.
   // Valid stays high on return so back-to-back bytes need no extra edge.
   task automatic send_rx_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                               input bit typed_emit = 1'b0,
                               input logic [BYTE_W-1:0] typed_out = '0);
      sgcp_step_type step;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      step = parse_step(parse_state_mirror, parse_en_mirror, b);
      sent_bytes++;
      parse_state_mirror = step.next_state;
      if (typed) begin
         if (typed_emit)
            pending_out_bytes.push_back(typed_out);
      end else if (step.emit) begin
         pending_out_bytes.push_back(step.out_byte);
      end
   endtask

   // Drop valid and wait until every expected result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_out_bytes.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_parse_enable(input logic en);
      csr_we <= 1'b1;
      csr_wdata <= en;
      @(posedge clock);
      csr_we <= 1'b0;
      parse_en_mirror = en;
   endtask

   // One random command: key, '=', data of the length the key calls for, and
   // now and then a stray byte while waiting, an '=' in the data, or a byte
   // after the data (otherwise the next command's first letter closes it).
   task automatic send_gain_command();
      logic [BYTE_W-1:0] first;
      logic [BYTE_W-1:0] second;
      int                data_len;
      first = $urandom_range(0, 1) ? CH_K : CH_S;
      second = key_seconds[$urandom_range(0, 4)];
      send_rx_byte(first);
      send_rx_byte(second);
      if ($urandom_range(0, 7) == 0)
         send_rx_byte(8'($urandom_range(0, 255)));
      send_rx_byte(CH_EQ);
      if (first == CH_S && second == CH_D)
         data_len = 0;
      else if (first == CH_S && (second == CH_A || second == CH_I))
         data_len = 3;
      else
         data_len = 5;
      repeat (data_len)
         send_rx_byte(($urandom_range(0, 15) == 0) ? CH_EQ : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1))
         send_rx_byte(8'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed commands; the rest raw noise or a key cut short.
   task automatic send_random_stretch();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         send_gain_command();
      end else if (pick < 9) begin
         repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
         send_rx_byte($urandom_range(0, 1) ? CH_K : CH_S);
         send_rx_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic run_random_phase(input int target);
      int start;
      start = sent_bytes;
      while (sent_bytes - start < target)
         send_random_stretch();
   endtask

   // Result side: check every transfer against the oldest expectation, then
   // choose the next cycle's stall (random, or the one long hold-off).
   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_out_bytes.size() == 0) begin
            report_mismatch("result with none expected", rsp_out_byte, '0);
         end else begin
            want = pending_out_bytes.pop_front();
            if (rsp_out_byte !== want)
               report_mismatch("result mismatch", rsp_out_byte, want);
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; write the enable when a row asks for a new setting.
      send_idle_pct = 12;
      recv_idle_pct = 47;
      write_parse_enable(1'b0);
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed_rows[i].parse_en != parse_en_mirror) begin
            wait_drained();
            write_parse_enable(directed_rows[i].parse_en);
         end
         send_rx_byte(directed_rows[i].rx, directed_rows[i].typed,
                      directed_rows[i].emit, directed_rows[i].out);
      end

      // Sender idles lightly, receiver heavily.
      run_random_phase(540);

      // Parsing off: everything is dropped and the state holds.
      wait_drained();
      write_parse_enable(1'b0);
      repeat (30) send_random_stretch();

      // Sender idles heavily, receiver lightly.
      wait_drained();
      write_parse_enable(1'b1);
      send_idle_pct = 47;
      recv_idle_pct = 12;
      run_random_phase(540);

      // No idling; the receiver holds off once for a long stretch.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_arm = 1'b1;
      run_random_phase(560);

      wait_drained();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
